// ----- hdl/dcu_pkg.sv -----
// Package for the Drude current update block: payload, queue entry and configuration types.
// No dependencies.
`default_nettype none

package dcu_pkg;

  // Grid size default, handed down from the top level.
  localparam int unsigned DCU_CELLS_DEF = 256;
  // Depth of the queue between front and back end.
  localparam int unsigned DCU_QUEUE_DEPTH = 4;
  // APB address width: six word-spaced registers.
  localparam int unsigned DCU_ADDR_W = 5;

  typedef struct packed {
    logic [7:0]         cell_index;
    logic signed [31:0] field_next;
    logic signed [31:0] field_prev;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         cell_out;
    logic signed [31:0] current_out;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic               region_enable;
    logic [7:0]         region_first;
    logic [7:0]         region_last;
    logic signed [31:0] own_gain;
    logic signed [31:0] history_gain;
    logic signed [31:0] drive_gain;
  } cfg_t;

  // How the back end treats an item.
  typedef enum logic [1:0] {
    KIND_OOB    = 2'd0,  // cell beyond the grid: emit zero
    KIND_HOLD   = 2'd1,  // outside the region: emit stored current
    KIND_UPDATE = 2'd2   // inside the region: compute and write back
  } kind_e;

  typedef struct packed {
    logic [7:0]         cell_index;
    kind_e              kind;
    logic signed [32:0] dfield;
  } q_entry_t;

endpackage

`default_nettype wire

// ----- hdl/dcu_front.sv -----
// Front end: accepts input items, classifies them against the region, forms the field difference.
// Depends on dcu_pkg.
`default_nettype none

module dcu_front import dcu_pkg::*; #(
  parameter int unsigned CELLS = DCU_CELLS_DEF
) (
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  input  wire cfg_t     cfg_i,
  input  wire logic     q_full_i,
  input  wire logic     clearing_i,
  output logic          push_o,
  output q_entry_t      entry_o
);

  logic oob;
  logic in_region;

  assign in_ready_o = !q_full_i && !clearing_i;
  assign push_o     = in_valid_i && in_ready_o;

  // cell <= min(last, CELLS-1) is the same as cell <= last and not beyond the grid
  assign oob       = 32'(in_item_i.cell_index) >= CELLS;
  assign in_region = cfg_i.region_enable && !oob
                     && (in_item_i.cell_index >= cfg_i.region_first)
                     && (in_item_i.cell_index <= cfg_i.region_last);

  always_comb begin
    entry_o.cell_index = in_item_i.cell_index;
    if (oob) begin
      entry_o.kind = KIND_OOB;
    end else if (in_region) begin
      entry_o.kind = KIND_UPDATE;
    end else begin
      entry_o.kind = KIND_HOLD;
    end
    entry_o.dfield = 33'(in_item_i.field_next) - 33'(in_item_i.field_prev);
  end

endmodule

`default_nettype wire

// ----- hdl/dcu_queue.sv -----
// Short FIFO of classified items between front and back end.
// Depends on dcu_pkg.
`default_nettype none

module dcu_queue import dcu_pkg::*; #(
  parameter int unsigned DEPTH = DCU_QUEUE_DEPTH
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire q_entry_t entry_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output q_entry_t      head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  q_entry_t        entries_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/dcu_back.sv -----
// Back end: current stores, multiply/sum/round pipeline, write-back and output register.
// Depends on dcu_pkg.
`default_nettype none

module dcu_back import dcu_pkg::*; #(
  parameter int unsigned CELLS = DCU_CELLS_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire cfg_t     cfg_i,
  input  wire logic     head_valid_i,
  input  wire q_entry_t head_i,
  output logic          pop_o,
  output logic          clearing_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  localparam int unsigned AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam logic [AW-1:0] LastIdx = AW'(CELLS - 1);
  localparam logic signed [65:0] RoundHalf = 66'sd536870912;  // 2^29

  // current stores
  logic [31:0] mem_now_q    [CELLS];
  logic [31:0] mem_before_q [CELLS];

  logic              clearing_q;
  logic [AW-1:0]     clr_q;

  logic              adv, hazard;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic              wr_en;
  logic [31:0]       wr_now, wr_before;
  logic signed [31:0] now_rd_q, before_rd_q;

  // stage 1: read data arrives
  logic               v1_q;
  logic [7:0]         cell1_q;
  kind_e              kind1_q;
  logic signed [32:0] dfield1_q;
  // stage 2: products
  logic               v2_q;
  logic [7:0]         cell2_q;
  kind_e              kind2_q;
  logic [31:0]        now2_q;
  logic signed [63:0] p_own2_q, p_hist2_q;
  logic signed [64:0] p_drv2_q;
  // stage 3: partial sums
  logic               v3_q;
  logic [7:0]         cell3_q;
  kind_e              kind3_q;
  logic [31:0]        now3_q;
  logic signed [65:0] sum_a3_q, sum_b3_q;
  // stage 4: total, round, saturate, write back
  logic               v4_q;
  logic [7:0]         cell4_q;
  kind_e              kind4_q;
  logic [31:0]        now4_q;
  logic signed [66:0] total4_q;
  logic signed [36:0] rounded;
  logic               sat_hi, sat_lo;
  logic [31:0]        result4;

  logic       out_valid_q;
  out_item_t  out_q;
  kind_e      kind_out_q;

  assign adv = !out_valid_q || out_ready_i;

  // an item waits while an earlier update of the same cell is still in flight
  assign hazard = (v1_q && kind1_q == KIND_UPDATE && cell1_q == head_i.cell_index)
               || (v2_q && kind2_q == KIND_UPDATE && cell2_q == head_i.cell_index)
               || (v3_q && kind3_q == KIND_UPDATE && cell3_q == head_i.cell_index)
               || (v4_q && kind4_q == KIND_UPDATE && cell4_q == head_i.cell_index);

  assign pop_o      = head_valid_i && adv && !hazard && !clearing_q;
  assign clearing_o = clearing_q;
  assign rd_addr    = (head_i.kind == KIND_OOB) ? '0 : AW'(head_i.cell_index);

  // rounding: add half, floor by 2^30
  assign rounded = total4_q[66:30];
  assign sat_hi  = !rounded[36] && (rounded[35:31] != '0);
  assign sat_lo  = rounded[36] && (rounded[35:31] != '1);
  assign result4 = sat_hi ? 32'h7FFF_FFFF : (sat_lo ? 32'h8000_0000 : rounded[31:0]);

  assign wr_en     = clearing_q || (adv && v4_q && kind4_q == KIND_UPDATE);
  assign wr_addr   = clearing_q ? clr_q : AW'(cell4_q);
  assign wr_now    = clearing_q ? '0 : result4;
  assign wr_before = clearing_q ? '0 : now4_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_now_q[wr_addr]    <= wr_now;
      mem_before_q[wr_addr] <= wr_before;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      now_rd_q    <= mem_now_q[rd_addr];
      before_rd_q <= mem_before_q[rd_addr];
    end
  end

  // clearing pass after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      if (clr_q == LastIdx) begin
        clearing_q <= 1'b0;
      end else begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= pop_o;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cell1_q   <= head_i.cell_index;
      kind1_q   <= head_i.kind;
      dfield1_q <= head_i.dfield;

      cell2_q   <= cell1_q;
      kind2_q   <= kind1_q;
      now2_q    <= now_rd_q;
      p_own2_q  <= $signed(cfg_i.own_gain) * now_rd_q;
      p_hist2_q <= $signed(cfg_i.history_gain) * before_rd_q;
      p_drv2_q  <= $signed(cfg_i.drive_gain) * dfield1_q;

      cell3_q   <= cell2_q;
      kind3_q   <= kind2_q;
      now3_q    <= now2_q;
      sum_a3_q  <= 66'(p_own2_q) + 66'(p_hist2_q);
      sum_b3_q  <= 66'(p_drv2_q) + RoundHalf;

      cell4_q   <= cell3_q;
      kind4_q   <= kind3_q;
      now4_q    <= now3_q;
      total4_q  <= 67'(sum_a3_q) + 67'(sum_b3_q);

      out_q.cell_out <= cell4_q;
      kind_out_q     <= kind4_q;
      case (kind4_q)
        KIND_UPDATE: begin
          out_q.current_out <= result4;
          out_q.saturated   <= sat_hi || sat_lo;
        end
        KIND_HOLD: begin
          out_q.current_out <= now4_q;
          out_q.saturated   <= 1'b0;
        end
        default: begin
          out_q.current_out <= '0;
          out_q.saturated   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef SYNTHESIS
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !pop_o && !v1_q && !v2_q && !v3_q && !v4_q && !out_valid_q)
    else $error("item in pipeline during clearing pass");

  a_clear_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !clearing_q |=> !clearing_q)
    else $error("clearing pass restarted");

  a_sat_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.saturated |-> kind_out_q == KIND_UPDATE)
    else $error("saturation flagged on non-updating item");

  a_oob_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_out_q == KIND_OOB |-> out_q.current_out == '0)
    else $error("off-grid item gave non-zero current");
`endif

endmodule

`default_nettype wire

// ----- hdl/drude_current_update.sv -----
// Path: an accepted item passes through the queue, the back-end pipeline and the output register.
// Throughput: one item per cycle without output stall; an item whose cell is still
//   being updated by one of the four items before it waits for that update's write-back.
// Reset: registers clear at once; a clearing pass then zeroes both current stores,
//   during which in_ready_o is low (configuration writes are still taken).
`default_nettype none

module drude_current_update import dcu_pkg::*; #(
  parameter int unsigned CELLS = DCU_CELLS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // input items
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  // result items
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  // APB configuration port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [DCU_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // Register map, word addresses.
  typedef enum logic [2:0] {
    REG_REGION_ENABLE = 3'd0,
    REG_REGION_FIRST  = 3'd1,
    REG_REGION_LAST   = 3'd2,
    REG_OWN_GAIN      = 3'd3,
    REG_HISTORY_GAIN  = 3'd4,
    REG_DRIVE_GAIN    = 3'd5
  } reg_idx_e;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     wr_strobe;

  logic     q_full, q_valid, q_push, q_pop;
  q_entry_t q_in, q_head;
  logic     clearing;

  // ---------------------------------------------------------------------------
  // Configuration registers. Software must write them only while the block is
  // idle, so items in flight see no change of gains or region; the block does not enforce it.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign reg_idx   = reg_idx_e'(paddr[4:2]);
  assign wr_strobe = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_strobe) begin
      case (reg_idx)
        REG_REGION_ENABLE: cfg_q.region_enable <= pwdata[0];
        REG_REGION_FIRST:  cfg_q.region_first  <= pwdata[7:0];
        REG_REGION_LAST:   cfg_q.region_last   <= pwdata[7:0];
        REG_OWN_GAIN:      cfg_q.own_gain      <= pwdata;
        REG_HISTORY_GAIN:  cfg_q.history_gain  <= pwdata;
        REG_DRIVE_GAIN:    cfg_q.drive_gain    <= pwdata;
        default: ;  // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_REGION_ENABLE: prdata = 32'(cfg_q.region_enable);
      REG_REGION_FIRST:  prdata = 32'(cfg_q.region_first);
      REG_REGION_LAST:   prdata = 32'(cfg_q.region_last);
      REG_OWN_GAIN:      prdata = cfg_q.own_gain;
      REG_HISTORY_GAIN:  prdata = cfg_q.history_gain;
      REG_DRIVE_GAIN:    prdata = cfg_q.drive_gain;
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Front end: takes an item, decides off-grid / outside / inside the region
  // and forms the exact 33-bit field difference.
  // ---------------------------------------------------------------------------
  dcu_front #(
    .CELLS (CELLS)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .q_full_i   (q_full),
    .clearing_i (clearing),
    .push_o     (q_push),
    .entry_o    (q_in)
  );

  // Queue decouples acceptance from the back end's stalls and interlocks.
  dcu_queue #(
    .DEPTH (DCU_QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  // ---------------------------------------------------------------------------
  // Back end: store read, three parallel multiplies, two adder stages,
  // round/saturate with write-back, then the output register. The whole
  // pipe moves together whenever the output register is free or taken.
  // ---------------------------------------------------------------------------
  dcu_back #(
    .CELLS (CELLS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (q_valid),
    .head_i       (q_head),
    .pop_o        (q_pop),
    .clearing_o   (clearing),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

`default_nettype wire
